/* src/csel_pkg.sv */
// Package for the checkerboard threshold select block.
// Holds field widths, configuration register codes, shared types and helpers.
// No dependencies.
package csel_pkg;

    // Payload widths
    localparam int INDEX_W  = 8;
    localparam int OFFSET_W = 32;
    localparam int NUMBER_W = 32;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] CFG_CUTOFF        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PART          = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_CHANNELS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH         = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_BATCH_COUNT   = 3'd5;

    // Register widths
    localparam int CUTOFF_W = 6;
    localparam int HALF_W   = 11;
    localparam int HEIGHT_W = 13;
    localparam int WIDTH_W  = 13;
    localparam int BATCH_W  = 9;

    // Cycles the derived size products need after a register write
    localparam int SETTLE_CYCLES = 3;
    localparam int SETTLE_W      = 2;

    // Derived configuration handed to the datapath
    typedef struct packed {
        logic [CUTOFF_W-1:0] cutoff;
        logic                part;
        logic [OFFSET_W-1:0] plane;       // height * width
        logic [OFFSET_W-1:0] half_plane;  // half_channels * plane
        logic [OFFSET_W-1:0] image_step;  // (2*half_channels - 1) * plane + 1
        logic                settled;     // products match the registers, no write offered
    } cfg_derived_t;

    // One kept beat between the scan stage and the result register
    typedef struct packed {
        logic [INDEX_W-1:0]  kept_index;
        logic [OFFSET_W-1:0] base_offset;
        logic                upper_half;
        logic [NUMBER_W-1:0] kept_number;
    } scan_beat_t;

    // Zero reads as one, above the maximum saturates
    function automatic logic [31:0] clamp_size(logic [31:0] v, logic [31:0] max_v);
        logic [31:0] r;
        if (v == 32'd0)
            r = 32'd1;
        else if (v > max_v)
            r = max_v;
        else
            r = v;
        return r;
    endfunction

endpackage

/* src/csel_if.sv */
// Handshake channels of the checkerboard threshold select block.
// Depends on csel_pkg for the payload widths.
interface csel_index_if import csel_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] index_value;

    modport source (output valid, output index_value, input ready);
    modport sink (input valid, input index_value, output ready);
endinterface

interface csel_result_if import csel_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [INDEX_W-1:0]  kept_index;
    logic [OFFSET_W-1:0] tensor_offset;
    logic [NUMBER_W-1:0] kept_number;

    modport source (output valid, output kept_index, output tensor_offset,
                    output kept_number, input ready);
    modport sink (input valid, input kept_index, input tensor_offset,
                  input kept_number, output ready);
endinterface

interface csel_cfg_if import csel_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* src/csel_cfg.sv */
// Configuration registers and derived size products.
// Depends on csel_pkg and csel_cfg_if.
module csel_cfg import csel_pkg::*; #(
    parameter int MAX_HALF_CHANNELS = 1024,
    parameter int MAX_HEIGHT        = 4096,
    parameter int MAX_WIDTH         = 4096,
    parameter int MAX_BATCH         = 256,
    localparam int HC_W = $clog2(MAX_HALF_CHANNELS + 1),
    localparam int H_W  = $clog2(MAX_HEIGHT + 1),
    localparam int W_W  = $clog2(MAX_WIDTH + 1),
    localparam int B_W  = $clog2(MAX_BATCH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    csel_cfg_if.sink          cfg,
    output cfg_derived_t      derived,
    output logic [HC_W-1:0]   half_size,
    output logic [H_W-1:0]    height_size,
    output logic [W_W-1:0]    width_size,
    output logic [B_W-1:0]    batch_size
);

    logic [CUTOFF_W-1:0] cutoff_reg;
    logic                part_reg;
    logic [HALF_W-1:0]   half_channels_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [BATCH_W-1:0]  batch_count_reg;

    logic [HC_W-1:0]     half_c_reg;
    logic [H_W-1:0]      height_c_reg;
    logic [W_W-1:0]      width_c_reg;
    logic [B_W-1:0]      batch_c_reg;
    logic [OFFSET_W-1:0] plane_reg;
    logic [OFFSET_W-1:0] half_plane_reg;
    logic [OFFSET_W-1:0] image_step_reg;
    logic [SETTLE_W-1:0] settle_reg;
    logic [SETTLE_W-1:0] settle_next;

    logic                cfg_write;
    logic [H_W+W_W-1:0]  plane_prod;
    logic [HC_W+OFFSET_W-1:0] half_plane_prod;
    logic [HC_W:0]       chans_less_one;
    logic [HC_W+OFFSET_W:0]   image_step_prod;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    // Register writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg        <= '0;
            part_reg          <= 1'b0;
            half_channels_reg <= HALF_W'(1);
            height_reg        <= HEIGHT_W'(1);
            width_reg         <= WIDTH_W'(1);
            batch_count_reg   <= BATCH_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg.index)
                CFG_CUTOFF:        cutoff_reg        <= cfg.data[CUTOFF_W-1:0];
                CFG_PART:          part_reg          <= cfg.data[0];
                CFG_HALF_CHANNELS: half_channels_reg <= cfg.data[HALF_W-1:0];
                CFG_HEIGHT:        height_reg        <= cfg.data[HEIGHT_W-1:0];
                CFG_WIDTH:         width_reg         <= cfg.data[WIDTH_W-1:0];
                CFG_BATCH_COUNT:   batch_count_reg   <= cfg.data[BATCH_W-1:0];
                default:           ;
            endcase
        end
    end

    // Products: the plane, then both steps from the registered plane
    assign plane_prod      = H_W'(height_c_reg) * W_W'(width_c_reg);
    assign half_plane_prod = (HC_W+OFFSET_W)'(half_c_reg) * (HC_W+OFFSET_W)'(plane_reg);
    assign chans_less_one  = {half_c_reg, 1'b0} - (HC_W+1)'(1);
    assign image_step_prod = (HC_W+OFFSET_W+1)'(chans_less_one)
                           * (HC_W+OFFSET_W+1)'(plane_reg);

    // Clamp, plane, then per-half and per-image steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_c_reg     <= HC_W'(1);
            height_c_reg   <= H_W'(1);
            width_c_reg    <= W_W'(1);
            batch_c_reg    <= B_W'(1);
            plane_reg      <= OFFSET_W'(1);
            half_plane_reg <= OFFSET_W'(1);
            image_step_reg <= OFFSET_W'(2);
        end
        else
        begin
            half_c_reg     <= HC_W'(clamp_size(32'(half_channels_reg), MAX_HALF_CHANNELS));
            height_c_reg   <= H_W'(clamp_size(32'(height_reg), MAX_HEIGHT));
            width_c_reg    <= W_W'(clamp_size(32'(width_reg), MAX_WIDTH));
            batch_c_reg    <= B_W'(clamp_size(32'(batch_count_reg), MAX_BATCH));
            plane_reg      <= OFFSET_W'(plane_prod);
            half_plane_reg <= OFFSET_W'(half_plane_prod);
            image_step_reg <= OFFSET_W'(image_step_prod) + OFFSET_W'(1);
        end
    end

    // Hold off input beats until the products have caught up
    always_comb
    begin
        if (cfg_write)
            settle_next = SETTLE_W'(SETTLE_CYCLES);
        else if (settle_reg != '0)
            settle_next = settle_reg - SETTLE_W'(1);
        else
            settle_next = settle_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_reg <= '0;
        else
            settle_reg <= settle_next;
    end

    assign derived.cutoff     = cutoff_reg;
    assign derived.part       = part_reg;
    assign derived.plane      = plane_reg;
    assign derived.half_plane = half_plane_reg;
    assign derived.image_step = image_step_reg;
    assign derived.settled    = (settle_reg == '0) && !cfg.valid;

    assign half_size   = half_c_reg;
    assign height_size = height_c_reg;
    assign width_size  = width_c_reg;
    assign batch_size  = batch_c_reg;

    // A write always restarts the settle window
    a_write_holds_off: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> !derived.settled)
        else $error("datapath released right after a register write");

endmodule

/* src/csel_scan.sv */
// Position counters, incremental offsets and the input register stage.
// Depends on csel_pkg and csel_index_if.
module csel_scan import csel_pkg::*; #(
    parameter int MAX_HALF_CHANNELS = 1024,
    parameter int MAX_HEIGHT        = 4096,
    parameter int MAX_WIDTH         = 4096,
    parameter int MAX_BATCH         = 256,
    localparam int HC_W = $clog2(MAX_HALF_CHANNELS + 1),
    localparam int H_W  = $clog2(MAX_HEIGHT + 1),
    localparam int W_W  = $clog2(MAX_WIDTH + 1),
    localparam int B_W  = $clog2(MAX_BATCH + 1)
) (
    input  logic            clk,
    input  logic            rst_n,
    csel_index_if.sink      index_stream,
    input  cfg_derived_t    derived,
    input  logic [HC_W-1:0] half_size,
    input  logic [H_W-1:0]  height_size,
    input  logic [W_W-1:0]  width_size,
    input  logic [B_W-1:0]  batch_size,
    input  logic            take,
    output logic            beat_valid,
    output scan_beat_t      beat
);

    localparam int CH_W  = (MAX_HALF_CHANNELS > 1) ? $clog2(MAX_HALF_CHANNELS) : 1;
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int IMG_W = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;

    logic [CH_W-1:0]     channel_count_reg, channel_count_next;
    logic [COL_W-1:0]    column_count_reg, column_count_next;
    logic [ROW_W-1:0]    row_count_reg, row_count_next;
    logic [IMG_W-1:0]    image_count_reg, image_count_next;
    logic [OFFSET_W-1:0] pixel_base_reg, pixel_base_next;
    logic [OFFSET_W-1:0] channel_step_reg, channel_step_next;
    logic [NUMBER_W-1:0] kept_total_reg, kept_total_next;
    logic                beat_valid_reg, beat_valid_next;
    scan_beat_t          beat_reg;

    logic                accept;
    logic                keep;
    logic                even_pixel;
    logic                upper_half;
    logic                channel_more, column_more, row_more, image_more;

    assign index_stream.ready = derived.settled && (!beat_valid_reg || take);
    assign accept = index_stream.valid && index_stream.ready;

    assign keep       = index_stream.index_value > INDEX_W'(derived.cutoff);
    assign even_pixel = (column_count_reg[0] ^ row_count_reg[0]) == 1'b0;
    assign upper_half = derived.part ? even_pixel : !even_pixel;

    assign channel_more = (HC_W'(channel_count_reg) + HC_W'(1)) < half_size;
    assign column_more  = (W_W'(column_count_reg) + W_W'(1)) < width_size;
    assign row_more     = (H_W'(row_count_reg) + H_W'(1)) < height_size;
    assign image_more   = (B_W'(image_count_reg) + B_W'(1)) < batch_size;

    // Advance channel, column, row, image; offsets follow by additions
    always_comb
    begin
        channel_count_next = channel_count_reg;
        column_count_next  = column_count_reg;
        row_count_next     = row_count_reg;
        image_count_next   = image_count_reg;
        pixel_base_next    = pixel_base_reg;
        channel_step_next  = channel_step_reg;
        if (channel_more)
        begin
            channel_count_next = channel_count_reg + CH_W'(1);
            channel_step_next  = channel_step_reg + derived.plane;
        end
        else
        begin
            channel_count_next = '0;
            channel_step_next  = '0;
            if (column_more)
            begin
                column_count_next = column_count_reg + COL_W'(1);
                pixel_base_next   = pixel_base_reg + OFFSET_W'(1);
            end
            else
            begin
                column_count_next = '0;
                if (row_more)
                begin
                    row_count_next  = row_count_reg + ROW_W'(1);
                    pixel_base_next = pixel_base_reg + OFFSET_W'(1);
                end
                else
                begin
                    row_count_next = '0;
                    if (image_more)
                    begin
                        image_count_next = image_count_reg + IMG_W'(1);
                        pixel_base_next  = pixel_base_reg + derived.image_step;
                    end
                    else
                    begin
                        image_count_next = '0;
                        pixel_base_next  = '0;
                    end
                end
            end
        end
    end

    assign kept_total_next = kept_total_reg + NUMBER_W'(1);

    // Input stage occupancy
    always_comb
    begin
        if (accept)
            beat_valid_next = keep;
        else if (take)
            beat_valid_next = 1'b0;
        else
            beat_valid_next = beat_valid_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= '0;
            column_count_reg  <= '0;
            row_count_reg     <= '0;
            image_count_reg   <= '0;
            pixel_base_reg    <= '0;
            channel_step_reg  <= '0;
            kept_total_reg    <= '0;
            beat_valid_reg    <= 1'b0;
        end
        else
        begin
            beat_valid_reg <= beat_valid_next;
            if (accept)
            begin
                channel_count_reg <= channel_count_next;
                column_count_reg  <= column_count_next;
                row_count_reg     <= row_count_next;
                image_count_reg   <= image_count_next;
                pixel_base_reg    <= pixel_base_next;
                channel_step_reg  <= channel_step_next;
                if (keep)
                    kept_total_reg <= kept_total_next;
            end
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (accept && keep)
        begin
            beat_reg.kept_index  <= index_stream.index_value;
            beat_reg.base_offset <= pixel_base_reg + channel_step_reg;
            beat_reg.upper_half  <= upper_half;
            beat_reg.kept_number <= kept_total_reg;
        end
    end

    assign beat_valid = beat_valid_reg;
    assign beat       = beat_reg;

    // A held beat stays put until the result register takes it
    a_beat_holds: assert property (@(posedge clk) disable iff (!rst_n)
        beat_valid_reg && !take |=> beat_valid_reg && $stable(beat_reg))
        else $error("input stage beat lost or changed while stalled");

    // Each kept beat bumps the running count by exactly one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && keep |=> kept_total_reg == $past(kept_total_reg) + NUMBER_W'(1))
        else $error("kept count did not advance by one");

    // Dropped beats leave the running count alone
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && keep) |=> $stable(kept_total_reg))
        else $error("kept count moved without a kept beat");

endmodule

/* src/csel_result.sv */
// Result register: adds the channel-half step and drives the result channel.
// Depends on csel_pkg and csel_result_if.
module csel_result import csel_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  cfg_derived_t    derived,
    input  logic            beat_valid,
    input  scan_beat_t      beat,
    output logic            take,
    csel_result_if.source   result_stream
);

    logic                result_valid_reg, result_valid_next;
    logic [INDEX_W-1:0]  kept_index_reg;
    logic [OFFSET_W-1:0] tensor_offset_reg, tensor_offset_next;
    logic [NUMBER_W-1:0] kept_number_reg;

    // Register free or draining this cycle
    assign take = !result_valid_reg || result_stream.ready;

    assign tensor_offset_next = beat.base_offset
                              + (beat.upper_half ? derived.half_plane : '0);
    assign result_valid_next  = take ? beat_valid : result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take && beat_valid)
        begin
            kept_index_reg    <= beat.kept_index;
            tensor_offset_reg <= tensor_offset_next;
            kept_number_reg   <= beat.kept_number;
        end
    end

    assign result_stream.valid         = result_valid_reg;
    assign result_stream.kept_index    = kept_index_reg;
    assign result_stream.tensor_offset = tensor_offset_reg;
    assign result_stream.kept_number   = kept_number_reg;

    // A beat moved out of the input stage shows up as a result
    a_beat_arrives: assert property (@(posedge clk) disable iff (!rst_n)
        take && beat_valid |=> result_valid_reg)
        else $error("beat taken from input stage but no result presented");

endmodule

/* src/checkerboard_threshold_select.sv */
// Checkerboard threshold select takes one index byte per beat in compact
// checkerboard order (channel fastest over half the channels, then column, row,
// image) and returns each byte above the cutoff with its NCHW offset mod 2^32
// and a running kept count. Sustained rate is one beat per cycle while results
// are taken; a result passes the input register, then the result register. Each
// configuration write closes the input while the size products (height*width,
// then half_channels*plane and the per-image step) pass through their multiply
// stages. Configuration must be written only while the block is idle.
module checkerboard_threshold_select import csel_pkg::*; #(
    parameter int MAX_HALF_CHANNELS = 1024,
    parameter int MAX_HEIGHT        = 4096,
    parameter int MAX_WIDTH         = 4096,
    parameter int MAX_BATCH         = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    csel_cfg_if.sink        cfg,
    csel_index_if.sink      index_stream,
    csel_result_if.source   result_stream
);

    localparam int HC_W = $clog2(MAX_HALF_CHANNELS + 1);
    localparam int H_W  = $clog2(MAX_HEIGHT + 1);
    localparam int W_W  = $clog2(MAX_WIDTH + 1);
    localparam int B_W  = $clog2(MAX_BATCH + 1);

    cfg_derived_t    derived;
    logic [HC_W-1:0] half_size;
    logic [H_W-1:0]  height_size;
    logic [W_W-1:0]  width_size;
    logic [B_W-1:0]  batch_size;
    logic            take;
    logic            beat_valid;
    scan_beat_t      beat;

    // Registers and size products
    csel_cfg #(
        .MAX_HALF_CHANNELS (MAX_HALF_CHANNELS),
        .MAX_HEIGHT        (MAX_HEIGHT),
        .MAX_WIDTH         (MAX_WIDTH),
        .MAX_BATCH         (MAX_BATCH)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .derived     (derived),
        .half_size   (half_size),
        .height_size (height_size),
        .width_size  (width_size),
        .batch_size  (batch_size)
    );

    // Counters and input stage
    csel_scan #(
        .MAX_HALF_CHANNELS (MAX_HALF_CHANNELS),
        .MAX_HEIGHT        (MAX_HEIGHT),
        .MAX_WIDTH         (MAX_WIDTH),
        .MAX_BATCH         (MAX_BATCH)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .index_stream (index_stream),
        .derived      (derived),
        .half_size    (half_size),
        .height_size  (height_size),
        .width_size   (width_size),
        .batch_size   (batch_size),
        .take         (take),
        .beat_valid   (beat_valid),
        .beat         (beat)
    );

    // Result register
    csel_result u_result (
        .clk           (clk),
        .rst_n         (rst_n),
        .derived       (derived),
        .beat_valid    (beat_valid),
        .beat          (beat),
        .take          (take),
        .result_stream (result_stream)
    );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Testbench for checkerboard_threshold_select: index beats under random flow control,
// a cycle-free predictor of kept beats, and a field-by-field check of every result.
// Depends on csel_pkg and the channel interfaces in src/csel_if.sv.
module tb_top;
    import csel_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 11;
    localparam int MAX_HALF     = 1024;
    localparam int MAX_ROWS     = 4096;
    localparam int MAX_COLS     = 4096;
    localparam int MAX_IMGS     = 256;
    localparam int ITEM_TARGET  = 430;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 80;

    typedef struct packed {
        logic [INDEX_W-1:0]  kept_index;
        logic [OFFSET_W-1:0] tensor_offset;
        logic [NUMBER_W-1:0] kept_number;
    } kept_beat_t;

    logic clk;
    logic rst_n;

    csel_cfg_if    cfg_bus ();
    csel_index_if  index_bus ();
    csel_result_if result_bus ();

    checkerboard_threshold_select #(
        .MAX_HALF_CHANNELS(MAX_HALF),
        .MAX_HEIGHT       (MAX_ROWS),
        .MAX_WIDTH        (MAX_COLS),
        .MAX_BATCH        (MAX_IMGS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_bus),
        .index_stream (index_bus),
        .result_stream(result_bus)
    );

    // Register mirror, raw values after the write masks
    logic [CUTOFF_W-1:0] cfg_cutoff;
    logic                cfg_part;
    logic [HALF_W-1:0]   cfg_half;
    logic [HEIGHT_W-1:0] cfg_rows;
    logic [WIDTH_W-1:0]  cfg_cols;
    logic [BATCH_W-1:0]  cfg_imgs;

    // Scan position and running offsets
    logic [9:0]          scan_channel;
    logic [11:0]         scan_column;
    logic [11:0]         scan_row;
    logic [7:0]          scan_image;
    logic [OFFSET_W-1:0] pixel_base;
    logic [OFFSET_W-1:0] channel_step;
    logic [NUMBER_W-1:0] kept_total;

    logic [INDEX_W-1:0] index_pending[$];
    kept_beat_t         kept_expected[$];
    kept_beat_t         oldest_kept;

    int  beats_queued = 0;
    int  beats_in     = 0;
    int  kept_seen    = 0;
    int  mismatches   = 0;
    int  settings_done = 0;
    int  src_gap      = 0;
    int  snk_gap      = 0;
    bit  src_burst    = 0;
    bit  snk_burst    = 0;
    int  hold_left    = 0;
    int  holds_done   = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Zero reads as one, anything above the limit saturates
    function automatic logic [31:0] fit_size(input logic [31:0] raw, input int limit);
        return (raw == 0) ? 32'd1 : ((raw > limit) ? 32'(limit) : raw);
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 20);
    endfunction

    // Compute the kept beat (if any) for one index and step the scan position
    function automatic void advance_scan(input logic [INDEX_W-1:0] v);
        logic [31:0]         half;
        logic [31:0]         rows;
        logic [31:0]         cols;
        logic [31:0]         imgs;
        logic [OFFSET_W-1:0] plane;
        logic [OFFSET_W-1:0] off;
        logic                even;
        logic                lower_half;
        half  = fit_size(32'(cfg_half), MAX_HALF);
        rows  = fit_size(32'(cfg_rows), MAX_ROWS);
        cols  = fit_size(32'(cfg_cols), MAX_COLS);
        imgs  = fit_size(32'(cfg_imgs), MAX_IMGS);
        plane = rows * cols;
        even  = ((32'(scan_column) + 32'(scan_row)) & 32'd1) == 32'd0;
        lower_half = cfg_part ? !even : even;

        if (32'(v) > 32'(cfg_cutoff)) begin
            off = pixel_base + channel_step;
            if (!lower_half)
                off += half * plane;
            kept_expected.push_back('{kept_index: v, tensor_offset: off,
                                      kept_number: kept_total});
            kept_total += 1;
        end

        // Channel fastest, then column, row, image; wrap at tensor end
        if (32'(scan_channel) + 1 < half) begin
            scan_channel += 1;
            channel_step += plane;
        end else begin
            scan_channel = '0;
            channel_step = '0;
            if (32'(scan_column) + 1 < cols) begin
                scan_column += 1;
                pixel_base  += 1;
            end else begin
                scan_column = '0;
                if (32'(scan_row) + 1 < rows) begin
                    scan_row   += 1;
                    pixel_base += 1;
                end else begin
                    scan_row = '0;
                    if (32'(scan_image) + 1 < imgs) begin
                        scan_image += 1;
                        pixel_base += 1 + (2 * half - 1) * plane;
                    end else begin
                        scan_image = '0;
                        pixel_base = '0;
                    end
                end
            end
        end
    endfunction

    // Index source: one beat per handshake, gaps drawn after each beat
    always @(posedge clk) begin
        if (rst_n) begin
            if (index_bus.valid && index_bus.ready) begin
                advance_scan(index_bus.index_value);
                beats_in <= beats_in + 1;
                src_gap = src_burst ? 0 : pick_gap();
            end
            if (!index_bus.valid || index_bus.ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    index_bus.valid <= 1'b0;
                end else if (index_pending.size() > 0) begin
                    index_bus.valid       <= 1'b1;
                    index_bus.index_value <= index_pending.pop_front();
                end else begin
                    index_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-offs while the source keeps offering beats
    always @(posedge clk) begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (holds_done < 2 && beats_in >= 100 + 250 * holds_done) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // Result sink: compare each kept beat with the oldest prediction
    always @(posedge clk) begin
        if (rst_n) begin
            if (result_bus.valid && result_bus.ready) begin
                kept_seen++;
                if (kept_expected.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected kept beat index %0d offset %0d number %0d",
                             $time, result_bus.kept_index, result_bus.tensor_offset,
                             result_bus.kept_number);
                end else begin
                    oldest_kept = kept_expected.pop_front();
                    if (result_bus.kept_index !== oldest_kept.kept_index) begin
                        mismatches++;
                        $display("%0t: kept_index expected %0d actual %0d", $time,
                                 oldest_kept.kept_index, result_bus.kept_index);
                    end
                    if (result_bus.tensor_offset !== oldest_kept.tensor_offset) begin
                        mismatches++;
                        $display("%0t: tensor_offset expected %0d actual %0d", $time,
                                 oldest_kept.tensor_offset, result_bus.tensor_offset);
                    end
                    if (result_bus.kept_number !== oldest_kept.kept_number) begin
                        mismatches++;
                        $display("%0t: kept_number expected %0d actual %0d", $time,
                                 oldest_kept.kept_number, result_bus.kept_number);
                    end
                end
                snk_gap = snk_burst ? 0 : pick_gap();
            end
            if (hold_left != 0)
                result_bus.ready <= 1'b0;
            else if (snk_gap > 0) begin
                snk_gap--;
                result_bus.ready <= 1'b0;
            end else
                result_bus.ready <= 1'b1;
        end
    end

    // One register write; valid is left high for a following write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] reg_index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= reg_index;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        case (reg_index)
            CFG_CUTOFF:        cfg_cutoff = value[CUTOFF_W-1:0];
            CFG_PART:          cfg_part   = value[0];
            CFG_HALF_CHANNELS: cfg_half   = value[HALF_W-1:0];
            CFG_HEIGHT:        cfg_rows   = value[HEIGHT_W-1:0];
            CFG_WIDTH:         cfg_cols   = value[WIDTH_W-1:0];
            CFG_BATCH_COUNT:   cfg_imgs   = value[BATCH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] cut, input logic [CFG_DATA_W-1:0] prt,
                             input logic [CFG_DATA_W-1:0] half,
                             input logic [CFG_DATA_W-1:0] rows,
                             input logic [CFG_DATA_W-1:0] cols,
                             input logic [CFG_DATA_W-1:0] imgs);
        write_reg(CFG_CUTOFF, cut);
        write_reg(CFG_PART, prt);
        write_reg(CFG_HALF_CHANNELS, half);
        write_reg(CFG_HEIGHT, rows);
        write_reg(CFG_WIDTH, cols);
        write_reg(CFG_BATCH_COUNT, imgs);
        cfg_bus.valid <= 1'b0;
        settings_done++;
    endtask

    task automatic queue_beat(input logic [INDEX_W-1:0] v);
        index_pending.push_back(v);
        beats_queued++;
    endtask

    // Random index, often right at the cutoff edge
    function automatic logic [INDEX_W-1:0] pick_index();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return INDEX_W'(cfg_cutoff) + INDEX_W'($urandom_range(0, 1));
        return INDEX_W'($urandom_range(0, 255));
    endfunction

    // Mostly small sizes, sometimes zero or all ones (saturates)
    function automatic logic [CFG_DATA_W-1:0] pick_size(input int small_max);
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return CFG_DATA_W'($urandom_range(1, small_max));
    endfunction

    // Wait until every queued beat is in and every kept beat is out
    task automatic wait_drained();
        while (beats_in != beats_queued || kept_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial begin
        int                    n;
        int                    r;
        logic [CFG_DATA_W-1:0] cut;
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.index         = '0;
        cfg_bus.data          = '0;
        index_bus.valid       = 1'b0;
        index_bus.index_value = '0;
        result_bus.ready      = 1'b0;
        cfg_cutoff   = '0;
        cfg_part     = 1'b0;
        cfg_half     = 1;
        cfg_rows     = 1;
        cfg_cols     = 1;
        cfg_imgs     = 1;
        scan_channel = '0;
        scan_column  = '0;
        scan_row     = '0;
        scan_image   = '0;
        pixel_base   = '0;
        channel_step = '0;
        kept_total   = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: cutoff zero, single-element tensor
        queue_beat(8'd0);
        queue_beat(8'd1);
        queue_beat(8'd255);
        queue_beat(8'd128);
        wait_drained();

        // Cutoff at its top through the write mask, other phase, zero sizes read as one
        configure('1, 13'd1, '0, '0, '0, '0);
        queue_beat(8'd63);
        queue_beat(8'd64);
        queue_beat(8'd255);
        queue_beat(8'd0);
        queue_beat(8'd200);
        wait_drained();

        // Small tensor, walking ones and a few patterns
        configure(13'd0, 13'd0, 13'd2, 13'd2, 13'd3, 13'd2);
        for (int b = 0; b < INDEX_W; b++)
            queue_beat(INDEX_W'(1 << b));
        queue_beat(8'd254);
        queue_beat(8'd127);
        queue_beat(8'd0);
        queue_beat(8'd85);
        wait_drained();

        // Saturated sizes: channel offsets run past 2^32
        configure(13'd31, 13'd1, '1, '1, 13'd4096, '1);
        for (int i = 0; i < 264; i++)
            queue_beat(pick_index());
        wait_drained();

        // Random settings; sizes change mid-tensor most of the time
        while (beats_queued < ITEM_TARGET) begin
            r = $urandom_range(0, 3);
            cut = (r == 0) ? 13'd0 : (r == 1) ? 13'd63 : CFG_DATA_W'($urandom_range(0, 63));
            cut[CFG_DATA_W-1:CUTOFF_W] = ($urandom_range(0, 3) == 0)
                                       ? (CFG_DATA_W-CUTOFF_W)'($urandom) : '0;
            configure(cut, CFG_DATA_W'($urandom_range(0, 1)), pick_size(4), pick_size(4),
                      pick_size(5), pick_size(3));
            src_burst = ($urandom_range(0, 3) == 0);
            snk_burst = ($urandom_range(0, 3) == 0);
            n = $urandom_range(8, 64);
            for (int i = 0; i < n; i++)
                queue_beat(pick_index());
            wait_drained();
        end
        wait_drained();

        if (kept_expected.size() != 0)
            $display("%0t: %0d kept beats never arrived", $time, kept_expected.size());
        $display("Covered %0d index beats under %0d register settings, %0d kept beats checked",
                 beats_in, settings_done, kept_seen);
        $display("Receiver held off %0d times for %0d cycles each", holds_done, HOLD_CYCLES);
        if (mismatches == 0 && kept_expected.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
